FILE: rtl/core/pskl_pkg.sv
package pskl_pkg;

	localparam int unsigned CAPACITY_DEFAULT = 32;
	localparam int unsigned COUNT_W = 6;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_ENTRY     = 3'd5,
		ST_EMPTY     = 3'd6,
		ST_UNUSED    = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [63:0]        name_high;
		logic [63:0]        name_middle;
		logic [63:0]        name_low;
		logic signed [31:0] priority_req;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [63:0]        out_name_high;
		logic [63:0]        out_name_middle;
		logic [63:0]        out_name_low;
		logic signed [31:0] out_priority;
		logic [5:0]         entry_count;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [63:0]        nh;
		logic [63:0]        nm;
		logic [63:0]        nl;
		logic signed [31:0] prio;
	} entry_t;

endpackage

FILE: rtl/core/priority_sorted_keyed_list_core.sv
// Channel | Direction | Payload     | Handshake
// in      | input     | in_item_t   | in_valid / in_stall
// out     | output    | out_item_t  | out_valid / out_stall
// An insert or remove does one memory read per cycle for the name search over the held entries,
// then one read and one write per cycle for the shift.
// A dump does a memory read and then an output load for each entry, and waits on out_stall.
// Reset clears the count and the control state; the entry memory is not cleared.
// The input is taken only while no item is at work; a result waits in the output register.
module priority_sorted_keyed_list_core import pskl_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SEARCH = 9'b000000010,
		S_DECIDE = 9'b000000100,
		S_SHIFT  = 9'b000001000,
		S_PLACE  = 9'b000010000,
		S_DUMP   = 9'b000100000,
		S_DWAIT  = 9'b001000000,
		S_RESULT = 9'b010000000,
		S_CLOSE  = 9'b100000000
	} state_t;

	state_t state_q;
	entry_t mem [CAPACITY];
	entry_t rd_s1;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic we;
	logic [AW-1:0] wr_addr;
	entry_t wr_data;

	in_item_t req_q;
	logic [COUNT_W:0] count_q;
	logic [COUNT_W:0] idx_q;
	logic [COUNT_W:0] pos_q;
	logic [COUNT_W:0] hit_q;
	logic found_q;
	logic full_q;
	logic pos_set_q;
	logic rd_pend_q;
	logic [COUNT_W:0] rd_idx_q;
	entry_t hold_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	logic name_eq;
	logic prio_le;
	assign name_eq = (rd_s1.nh == req_q.name_high) && (rd_s1.nm == req_q.name_middle)
		&& (rd_s1.nl == req_q.name_low);
	assign prio_le = (rd_s1.prio <= req_q.priority_req);

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	logic out_load;
	assign out_load = out_free && ((state_q == S_RESULT) || (state_q == S_DWAIT)
		|| (state_q == S_DUMP && count_q == '0));

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		we = 1'b0;
		wr_addr = '0;
		wr_data = hold_q;
		unique case (state_q)
			S_SEARCH: begin
				rd_en = (idx_q < count_q);
				rd_addr = idx_q[AW-1:0];
			end
			S_SHIFT: begin
				if (req_q.operation == OP_INSERT) begin
					rd_en = 1'b1;
					rd_addr = AW'(idx_q - 1'b1);
					we = rd_pend_q;
					wr_addr = AW'(rd_idx_q + 1'b1);
					wr_data = rd_s1;
				end else begin
					rd_en = 1'b1;
					rd_addr = AW'(idx_q + 1'b1);
					we = rd_pend_q;
					wr_addr = AW'(rd_idx_q - 1'b1);
					wr_data = rd_s1;
				end
			end
			S_PLACE: begin
				we = rd_pend_q;
				wr_addr = (req_q.operation == OP_INSERT) ? AW'(rd_idx_q + 1'b1)
					: AW'(rd_idx_q - 1'b1);
				wr_data = rd_s1;
			end
			S_CLOSE: begin
				we = (req_q.operation == OP_INSERT);
				wr_addr = pos_q[AW-1:0];
				wr_data = '{nh: req_q.name_high, nm: req_q.name_middle,
					nl: req_q.name_low, prio: req_q.priority_req};
			end
			S_DUMP: begin
				rd_en = out_free && (idx_q < count_q);
				rd_addr = idx_q[AW-1:0];
			end
			default: ;
		endcase
	end

	function automatic out_item_t plain(status_t st, logic [COUNT_W:0] cnt);
		out_item_t o;
		o = '0;
		o.status = st;
		o.entry_count = cnt[COUNT_W-1:0];
		o.last = 1'b1;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			hit_q <= '0;
			found_q <= 1'b0;
			full_q <= 1'b0;
			pos_set_q <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			out_valid <= out_load || (out_valid && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						idx_q <= '0;
						found_q <= 1'b0;
						full_q <= 1'b0;
						pos_set_q <= 1'b0;
						rd_pend_q <= 1'b0;
						pos_q <= count_q;
						unique case (op_t'(in_data.operation))
							OP_INSERT, OP_REMOVE: state_q <= S_SEARCH;
							OP_DUMP: state_q <= S_DUMP;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SEARCH: begin
					rd_pend_q <= (idx_q < count_q);
					rd_idx_q <= idx_q;
					if (idx_q < count_q) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_pend_q) begin
						if (name_eq && !found_q) begin
							found_q <= 1'b1;
							hit_q <= rd_idx_q;
						end
						if (!prio_le && !pos_set_q) begin
							pos_set_q <= 1'b1;
							pos_q <= rd_idx_q;
						end
					end
					if (!(idx_q < count_q)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rd_pend_q <= 1'b0;
					if (req_q.operation == OP_INSERT) begin
						if (found_q) begin
							hold_q <= '0;
							state_q <= S_RESULT;
							pos_q <= '0;
						end else if (count_q >= (COUNT_W+1)'(CAPACITY)) begin
							full_q <= 1'b1;
							state_q <= S_RESULT;
						end else begin
							idx_q <= count_q;
							state_q <= (count_q > pos_q) ? S_SHIFT : S_CLOSE;
						end
					end else begin
						if (!found_q) begin
							state_q <= S_RESULT;
						end else begin
							idx_q <= hit_q;
							state_q <= (hit_q + 1'b1 < count_q) ? S_SHIFT : S_CLOSE;
						end
					end
				end
				S_SHIFT: begin
					rd_pend_q <= 1'b1;
					if (req_q.operation == OP_INSERT) begin
						rd_idx_q <= idx_q - 1'b1;
						idx_q <= idx_q - 1'b1;
						if (idx_q - 1'b1 == pos_q) begin
							state_q <= S_PLACE;
						end
					end else begin
						rd_idx_q <= idx_q + 1'b1;
						idx_q <= idx_q + 1'b1;
						if (idx_q + 2'd2 >= count_q) begin
							state_q <= S_PLACE;
						end
					end
				end
				S_PLACE: begin
					rd_pend_q <= 1'b0;
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					if (req_q.operation == OP_INSERT) begin
						count_q <= count_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						if (req_q.operation == OP_INSERT) begin
							if (found_q) begin
								out_data <= plain(ST_DUPLICATE, count_q);
							end else if (full_q) begin
								out_data <= plain(ST_FULL, count_q);
							end else begin
								out_data <= plain(ST_INSERTED, count_q);
							end
						end else begin
							out_data <= plain(found_q ? ST_REMOVED : ST_NOT_FOUND, count_q);
						end
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (count_q == '0) begin
						if (out_free) begin
							out_data <= plain(ST_EMPTY, count_q);
							state_q <= S_IDLE;
						end
					end else if (out_free) begin
						rd_idx_q <= idx_q;
						idx_q <= idx_q + 1'b1;
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					if (out_free) begin
						out_data.status <= ST_ENTRY;
						out_data.out_name_high <= rd_s1.nh;
						out_data.out_name_middle <= rd_s1.nm;
						out_data.out_name_low <= rd_s1.nl;
						out_data.out_priority <= rd_s1.prio;
						out_data.entry_count <= count_q[COUNT_W-1:0];
						out_data.last <= (idx_q == count_q);
						state_q <= (idx_q == count_q) ? S_IDLE : S_DUMP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (COUNT_W+1)'(CAPACITY)) else $error("count over capacity");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !in_stall) else $error("idle but stalled");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DUMP || state_q == S_DWAIT) |-> !we)
		else $error("memory written outside update");
`endif

endmodule

FILE: bench/tb_checker.sv
`timescale 1ns / 100ps

module tb_checker import pskl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending
);

	localparam int CAP = CAPACITY_DEFAULT;

	entry_t    list_q[$];
	out_item_t result_q[$];

	function automatic out_item_t plain_result(status_t st, int cnt);
		out_item_t r;
		r = '0;
		r.status = st;
		r.entry_count = cnt[5:0];
		r.last = 1'b1;
		return r;
	endfunction

	function automatic int locate_name(in_item_t it);
		foreach (list_q[i])
			if (list_q[i].nh == it.name_high && list_q[i].nm == it.name_middle &&
			    list_q[i].nl == it.name_low)
				return i;
		return -1;
	endfunction

	task automatic predict_list_op(in_item_t it);
		int at;
		int pos;
		entry_t e;
		out_item_t r;
		case (op_t'(it.operation))
			OP_INSERT: begin
				if (locate_name(it) >= 0)
					result_q.push_back(plain_result(ST_DUPLICATE, list_q.size()));
				else if (list_q.size() >= CAP)
					result_q.push_back(plain_result(ST_FULL, list_q.size()));
				else begin
					pos = 0;
					while (pos < list_q.size() && list_q[pos].prio <= it.priority_req)
						pos++;
					e.nh = it.name_high;
					e.nm = it.name_middle;
					e.nl = it.name_low;
					e.prio = it.priority_req;
					list_q.insert(pos, e);
					result_q.push_back(plain_result(ST_INSERTED, list_q.size()));
				end
			end
			OP_REMOVE: begin
				at = locate_name(it);
				if (at < 0)
					result_q.push_back(plain_result(ST_NOT_FOUND, list_q.size()));
				else begin
					list_q.delete(at);
					result_q.push_back(plain_result(ST_REMOVED, list_q.size()));
				end
			end
			OP_DUMP: begin
				if (list_q.size() == 0)
					result_q.push_back(plain_result(ST_EMPTY, 0));
				else
					foreach (list_q[i]) begin
						r = plain_result(ST_ENTRY, list_q.size());
						r.out_name_high = list_q[i].nh;
						r.out_name_middle = list_q[i].nm;
						r.out_name_low = list_q[i].nl;
						r.out_priority = list_q[i].prio;
						r.last = (i == list_q.size() - 1);
						result_q.push_back(r);
					end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat %h", out_data);
				end else begin
					want = result_q.pop_front();
					if (out_data !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %h actual %h", want, out_data);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_list_op(in_data);
		end
		pending = result_q.size();
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import pskl_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	int        fail_count;
	int        pending;
	int        quiet_cycles;
	bit        calm;
	bit        hold_long;
	logic [63:0] name_pool [8][3];

	priority_sorted_keyed_list_core DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	tb_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_beat(op_t op, logic [63:0] h, logic [63:0] m, logic [63:0] l,
		logic [31:0] p);
		in_valid <= 1'b1;
		in_data <= '{operation: op, name_high: h, name_middle: m, name_low: l,
			priority_req: p};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			in_data <= '{operation: op_t'($urandom_range(0, 3)), name_high: rand64(),
				name_middle: rand64(), name_low: rand64(), priority_req: $urandom()};
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic send_pooled(op_t op);
		int k;
		logic [31:0] p;
		k = $urandom_range(0, 7);
		case ($urandom_range(0, 3))
			0: p = $urandom();
			1: p = $urandom_range(0, 3) - 2;
			2: p = 32'h7fffffff;
			default: p = 32'h80000000;
		endcase
		send_beat(op, name_pool[k][0], name_pool[k][1], name_pool[k][2], p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall <= 1'b0;
			end else
				out_stall <= 1'b0;
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else if (++quiet_cycles >= 20000) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int op_pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		hold_long = 1'b0;
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 3; j++)
				name_pool[i][j] = (i < 2) ? {64{i[0]}} : rand64();
		name_pool[2][1] = 64'h4100000000000000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(OP_DUMP, 0, 0, 0, 0);
		send_beat(OP_REMOVE, 0, 0, 0, 0);
		send_beat(OP_INSERT, '0, '0, '0, 32'h7fffffff);
		send_beat(OP_INSERT, '1, '1, '1, 32'h80000000);
		send_beat(OP_INSERT, 64'h41, 0, 0, 32'h7fffffff);
		send_beat(OP_INSERT, 64'h42, 0, 0, 32'h7fffffff);
		send_beat(OP_INSERT, 64'h43, 0, 0, 32'h80000000);
		send_beat(OP_INSERT, 0, 64'h41, 0, 5);
		send_beat(OP_INSERT, 0, 0, 64'h41, 5);
		send_beat(OP_INSERT, '0, '0, '0, 1);
		send_beat(OP_NONE, 64'h41, 0, 0, 0);
		send_beat(OP_DUMP, 0, 0, 0, 0);
		send_beat(OP_REMOVE, 64'h42, 0, 0, 0);
		send_beat(OP_REMOVE, 64'h42, 0, 0, 0);
		send_beat(OP_REMOVE, '1, '1, '1, 0);
		send_beat(OP_DUMP, 0, 0, 0, 0);
		for (int i = 0; i < 30; i++)
			send_beat(OP_INSERT, rand64(), 64'(i), rand64(), $urandom_range(0, 3));
		send_beat(OP_INSERT, 64'h99, 0, 0, 0);
		send_beat(OP_INSERT, 64'h41, 0, 0, 0);
		drain();

		hold_long = 1'b1;
		send_beat(OP_DUMP, 0, 0, 0, 0);
		send_beat(OP_DUMP, 0, 0, 0, 0);
		send_beat(OP_REMOVE, 64'h41, 0, 0, 0);
		drain();

		for (int n = 0; n < 280; n++) begin
			if (n == 230) calm = 1'b1;
			op_pick = $urandom_range(0, 19);
			if (op_pick < 9)
				send_pooled(OP_INSERT);
			else if (op_pick < 14)
				send_pooled(OP_REMOVE);
			else if (op_pick < 16)
				send_beat(OP_DUMP, rand64(), rand64(), rand64(), $urandom());
			else if (op_pick < 17)
				send_beat(OP_NONE, rand64(), rand64(), rand64(), $urandom());
			else if (op_pick < 19)
				send_beat(OP_INSERT, rand64(), rand64(), rand64(), $urandom());
			else
				send_beat(OP_REMOVE, rand64(), rand64(), rand64(), $urandom());
		end
		send_beat(OP_DUMP, 0, 0, 0, 0);
		drain();

		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
